/* src/pmu_pkg.sv */
// Shared types and constants for the Potts lattice Metropolis update block.
package pmu_pkg;

    // Default lattice geometry
    localparam int SIDE_DEF   = 512;
    localparam int LEVELS_DEF = 256;

    // Field widths
    localparam int SITE_W     = 18;
    localparam int SPIN_W     = 8;
    localparam int UNI_W      = 24;
    localparam int THR_W      = 25;
    localparam int MC_W       = 4;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int NUM_THRESH = 8;
    localparam int THR_IDX_W  = 3;

    // Wide enough to compare a site against the largest lattice size
    localparam int RANGE_W    = SITE_W + 3;

    // 1.0 in 1.24 fixed point
    localparam logic [THR_W-1:0] ONE_FIX = THR_W'(1 << 24);

    // Item codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // Neighbor slots
    localparam int NBR_LEFT  = 0;
    localparam int NBR_RIGHT = 1;
    localparam int NBR_UP    = 2;
    localparam int NBR_DOWN  = 3;
    localparam int NBR_NUM   = 4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COORD,
        ST_RD_L,
        ST_RD_R,
        ST_RD_U,
        ST_RD_D,
        ST_LAST,
        ST_DECIDE,
        ST_LD_OUT
    } pmu_state_t;

    // Sequencer controls for the coordinate unit
    typedef struct packed {
        logic capture;
        logic fix;
    } pmu_coord_ctl_t;

endpackage

/* src/potts_metropolis_update.sv */
// Top level of the Potts lattice Metropolis single-spin update block.
// Usage:
//   Items enter on start/busy: an item is taken at a clock edge with start
//   high and busy low. action selects a load (write spin_value to site) or
//   an update (propose spin_value at site against uniform).
//   Each item gives one result beat on done, valid for one cycle; the
//   receiver cannot stall it and none is needed.
//   Thresholds are written on cfg_valid/cfg_ready (ready is always high);
//   the user must write them only while the block is idle; the block does not enforce it.
// Timing:
//   A load of a legal value, or an item whose site lies off the lattice,
//   shows its result in the cycle after it is taken; busy stays low.
//   A load of an illegal value reads the site back through ST_LD_OUT and
//   returns it with accepted low. An update reads the center as it is
//   taken, ST_COORD settles the row and column, then the four neighbors go
//   through the single read port of the spin memory one per cycle, then
//   ST_DECIDE writes. busy is low again in the cycle that carries done, so
//   the next item may follow at once.
// Reset: rst_n clears the sequencer and sets every threshold to 1.0. The
//   lattice holds no reset value; sites must be loaded before they are read.
module potts_metropolis_update #(
    parameter int LATTICE_SIDE = pmu_pkg::SIDE_DEF,
    parameter int SPIN_LEVELS  = pmu_pkg::LEVELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Item channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                action,
    input  logic [pmu_pkg::SITE_W-1:0]          site,
    input  logic [pmu_pkg::SPIN_W-1:0]          spin_value,
    input  logic [pmu_pkg::UNI_W-1:0]           uniform,
    // Result beat
    output logic                                done,
    output logic                                accepted,
    output logic [pmu_pkg::SPIN_W-1:0]          spin_now,
    output logic signed [pmu_pkg::MC_W-1:0]     match_change,
    // Threshold writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmu_pkg::THR_W-1:0]           cfg_data
);
    import pmu_pkg::*;

    localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
    localparam int MEM_DEPTH  = (SITE_COUNT > (2 ** SITE_W)) ? (2 ** SITE_W) : SITE_COUNT;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    pmu_state_t               state_reg;
    pmu_state_t               state_next;

    logic [SPIN_W-1:0]        val_reg;
    logic [UNI_W-1:0]         uni_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic                     val_ok_reg;
    logic [SPIN_W-1:0]        old_reg;
    logic [SPIN_W-1:0]        old_next;
    logic [CNT_W-1:0]         old_m_reg;
    logic [CNT_W-1:0]         old_m_next;
    logic [CNT_W-1:0]         new_m_reg;
    logic [CNT_W-1:0]         new_m_next;

    logic                     done_reg;
    logic                     done_next;
    logic                     acc_reg;
    logic                     acc_next;
    logic [SPIN_W-1:0]        spin_reg;
    logic [SPIN_W-1:0]        spin_next;
    logic signed [MC_W-1:0]   mc_reg;
    logic signed [MC_W-1:0]   mc_next;

    logic                     take_item;
    logic                     in_range;
    logic                     val_ok;
    logic                     compare_en;
    logic                     capture_item;

    pmu_coord_ctl_t                     coord_ctl;
    logic [NBR_NUM-1:0][ADDR_W-1:0]     nbr_addr;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [SPIN_W-1:0]        mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic [SPIN_W-1:0]        mem_rdata;

    logic signed [MC_W-1:0]   d_val;
    logic [THR_W-1:0]         thresh;
    logic                     pass;
    logic                     take_spin;

    // Item checks
    assign take_item = start && !busy;
    assign in_range  = RANGE_W'(site) < RANGE_W'(SITE_COUNT);
    assign val_ok    = {1'b0, spin_value} < (SPIN_W + 1)'(SPIN_LEVELS);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // Decision on the counted matches
    assign d_val     = $signed(MC_W'(new_m_reg)) - $signed(MC_W'(old_m_reg));
    assign pass      = (d_val == '0) || (thresh >= {1'b0, uni_reg});
    assign take_spin = pass && val_ok_reg;

    pmu_spin_ram #(
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pmu_site_coord #(
        .LATTICE_SIDE (LATTICE_SIDE),
        .ADDR_W       (ADDR_W)
    ) u_coord (
        .clk      (clk),
        .ctl      (coord_ctl),
        .site     (site),
        .nbr_addr (nbr_addr)
    );

    pmu_thresh_regs u_thresh (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .match_change (d_val),
        .thresh       (thresh)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_item && in_range)
                begin
                    if (action == ACT_UPDATE)
                    begin
                        state_next = ST_COORD;
                    end
                    else if (!val_ok)
                    begin
                        state_next = ST_LD_OUT;
                    end
                end
            end
            ST_COORD:  state_next = ST_RD_L;
            ST_RD_L:   state_next = ST_RD_R;
            ST_RD_R:   state_next = ST_RD_U;
            ST_RD_U:   state_next = ST_RD_D;
            ST_RD_D:   state_next = ST_LAST;
            ST_LAST:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_IDLE;
            ST_LD_OUT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory access, counting and result beat
    always_comb
    begin
        coord_ctl    = '0;
        capture_item = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = val_reg;
        mem_raddr    = site[ADDR_W-1:0];
        compare_en   = 1'b0;
        old_next     = old_reg;
        done_next    = 1'b0;
        acc_next     = acc_reg;
        spin_next    = spin_reg;
        mc_next      = mc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                coord_ctl.capture = take_item;
                capture_item      = take_item;
                if (take_item)
                begin
                    if (!in_range)
                    begin
                        done_next = 1'b1;
                        acc_next  = 1'b0;
                        spin_next = '0;
                        mc_next   = '0;
                    end
                    else if ((action == ACT_LOAD) && val_ok)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = site[ADDR_W-1:0];
                        mem_wdata = spin_value;
                        done_next = 1'b1;
                        acc_next  = 1'b1;
                        spin_next = spin_value;
                        mc_next   = '0;
                    end
                end
            end
            ST_COORD:
            begin
                coord_ctl.fix = 1'b1;
                old_next      = mem_rdata;
            end
            ST_RD_L:
            begin
                mem_raddr = nbr_addr[NBR_LEFT];
            end
            ST_RD_R:
            begin
                mem_raddr  = nbr_addr[NBR_RIGHT];
                compare_en = 1'b1;
            end
            ST_RD_U:
            begin
                mem_raddr  = nbr_addr[NBR_UP];
                compare_en = 1'b1;
            end
            ST_RD_D:
            begin
                mem_raddr  = nbr_addr[NBR_DOWN];
                compare_en = 1'b1;
            end
            ST_LAST:
            begin
                compare_en = 1'b1;
            end
            ST_DECIDE:
            begin
                mem_we    = take_spin;
                done_next = 1'b1;
                acc_next  = take_spin;
                spin_next = take_spin ? val_reg : old_reg;
                mc_next   = d_val;
            end
            ST_LD_OUT:
            begin
                done_next = 1'b1;
                acc_next  = 1'b0;
                spin_next = mem_rdata;
                mc_next   = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Count neighbors matching the old and the proposed spin
    always_comb
    begin
        old_m_next = old_m_reg;
        new_m_next = new_m_reg;
        if (state_reg == ST_COORD)
        begin
            old_m_next = '0;
            new_m_next = '0;
        end
        else if (compare_en)
        begin
            old_m_next = old_m_reg + CNT_W'(mem_rdata == old_reg);
            new_m_next = new_m_reg + CNT_W'(mem_rdata == val_reg);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (capture_item)
        begin
            val_reg    <= spin_value;
            uni_reg    <= uniform;
            addr_reg   <= site[ADDR_W-1:0];
            val_ok_reg <= val_ok;
        end
        old_reg   <= old_next;
        old_m_reg <= old_m_next;
        new_m_reg <= new_m_next;
        acc_reg   <= acc_next;
        spin_reg  <= spin_next;
        mc_reg    <= mc_next;
    end

    assign done         = done_reg;
    assign accepted     = acc_reg;
    assign spin_now     = spin_reg;
    assign match_change = mc_reg;

`ifndef ASSERT_OFF
    // A result beat never overlaps work on an item
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result beat while busy");

    // The block only turns busy on a taken item
    assert property (@(posedge clk) disable iff (!rst_n) $rose(busy) |-> $past(start))
        else $error("busy without a start");

    // Every decision produces a beat in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_DECIDE) |=> done)
        else $error("decision without result beat");

    // Match counts stay within the four neighbors
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DECIDE) |-> (old_m_reg <= CNT_W'(4)) && (new_m_reg <= CNT_W'(4)))
        else $error("match count out of range");
`endif

endmodule

/* src/pmu_spin_ram.sv */
// Spin lattice storage: one write port, one registered read port.
module pmu_spin_ram #(
    parameter int DEPTH = pmu_pkg::SIDE_DEF * pmu_pkg::SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [$clog2(DEPTH)-1:0]            waddr,
    input  logic [pmu_pkg::SPIN_W-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]            raddr,
    output logic [pmu_pkg::SPIN_W-1:0]          rdata
);
    import pmu_pkg::*;

    logic [SPIN_W-1:0] mem [DEPTH];

    // Write one spin
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read one spin; the read data is registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* src/pmu_site_coord.sv */
// Row and column split of a site and the four wrapped neighbor addresses.
module pmu_site_coord #(
    parameter int LATTICE_SIDE = pmu_pkg::SIDE_DEF,
    parameter int ADDR_W       = 18
) (
    input  logic                                      clk,
    input  pmu_pkg::pmu_coord_ctl_t                   ctl,
    input  logic [pmu_pkg::SITE_W-1:0]                site,
    output logic [pmu_pkg::NBR_NUM-1:0][ADDR_W-1:0]   nbr_addr
);
    import pmu_pkg::*;

    localparam int SITE_COUNT = LATTICE_SIDE * LATTICE_SIDE;
    localparam int IDX_W      = $clog2(SITE_COUNT);
    localparam int ROW_W      = $clog2(LATTICE_SIDE);
    localparam int SHIFT      = SITE_W + ROW_W;
    localparam int RECIP      = (2 ** SHIFT) / LATTICE_SIDE;
    localparam int RECIP_W    = SITE_W + 1;
    localparam int PROD_W     = SHIFT + ROW_W;
    localparam int REM_W      = IDX_W + 1;

    logic [SITE_W-1:0]  site_reg;
    logic [ROW_W-1:0]   q_est_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   col_reg;

    logic [PROD_W-1:0]  prod;
    logic [REM_W-1:0]   rem;
    logic               rem_hi;
    logic [REM_W-1:0]   col_fix;
    logic [IDX_W-1:0]   site_idx;
    logic [IDX_W-1:0]   left_idx;
    logic [IDX_W-1:0]   right_idx;
    logic [IDX_W-1:0]   up_idx;
    logic [IDX_W-1:0]   down_idx;

    // Estimate the row by multiplying with the scaled reciprocal of the side
    assign prod = PROD_W'(site) * PROD_W'(RECIP_W'(RECIP));

    // Remainder of the estimate; it may still hold one extra side
    assign rem     = REM_W'(site_reg) - REM_W'(q_est_reg) * REM_W'(LATTICE_SIDE);
    assign rem_hi  = rem >= REM_W'(LATTICE_SIDE);
    assign col_fix = rem_hi ? rem - REM_W'(LATTICE_SIDE) : rem;

    // Hold the site and the row estimate, then settle row and column
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            site_reg  <= site;
            q_est_reg <= prod[SHIFT +: ROW_W];
        end
        if (ctl.fix)
        begin
            row_reg <= q_est_reg + ROW_W'(rem_hi);
            col_reg <= col_fix[ROW_W-1:0];
        end
    end

    // Step to each neighbor, wrapping at the lattice edges
    assign site_idx  = IDX_W'(site_reg);
    assign left_idx  = (col_reg == '0) ? site_idx + IDX_W'(LATTICE_SIDE - 1)
                                       : site_idx - IDX_W'(1);
    assign right_idx = (col_reg == ROW_W'(LATTICE_SIDE - 1))
                       ? site_idx - IDX_W'(LATTICE_SIDE - 1)
                       : site_idx + IDX_W'(1);
    assign up_idx    = (row_reg == '0) ? site_idx + IDX_W'(SITE_COUNT - LATTICE_SIDE)
                                       : site_idx - IDX_W'(LATTICE_SIDE);
    assign down_idx  = (row_reg == ROW_W'(LATTICE_SIDE - 1))
                       ? site_idx - IDX_W'(SITE_COUNT - LATTICE_SIDE)
                       : site_idx + IDX_W'(LATTICE_SIDE);

    assign nbr_addr[NBR_LEFT]  = left_idx[ADDR_W-1:0];
    assign nbr_addr[NBR_RIGHT] = right_idx[ADDR_W-1:0];
    assign nbr_addr[NBR_UP]    = up_idx[ADDR_W-1:0];
    assign nbr_addr[NBR_DOWN]  = down_idx[ADDR_W-1:0];

endmodule

/* src/pmu_thresh_regs.sv */
// Acceptance threshold registers and the saturated lookup by match change.
module pmu_thresh_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [pmu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pmu_pkg::THR_W-1:0]          cfg_data,
    input  logic signed [pmu_pkg::MC_W-1:0]    match_change,
    output logic [pmu_pkg::THR_W-1:0]          thresh
);
    import pmu_pkg::*;

    logic [THR_W-1:0]     thr_reg [NUM_THRESH];
    logic [MC_W-1:0]      slot_sum;
    logic [THR_IDX_W-1:0] slot;
    logic [THR_W-1:0]     raw;

    // Write a threshold; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_THRESH; i++)
            begin
                thr_reg[i] <= ONE_FIX;
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_THRESH)))
        begin
            thr_reg[cfg_index[THR_IDX_W-1:0]] <= cfg_data;
        end
    end

    // Map -4..-1 to slots 0..3 and +1..+4 to slots 4..7
    assign slot_sum = match_change[MC_W-1] ? $unsigned(match_change) + MC_W'(4)
                                           : $unsigned(match_change) + MC_W'(3);
    assign slot     = slot_sum[THR_IDX_W-1:0];
    assign raw      = thr_reg[slot];

    // Saturate at 1.0
    assign thresh = (raw > ONE_FIX) ? ONE_FIX : raw;

endmodule
